[hw/rtl/dbe_pkg.sv]
// Shared constants and types for the diffuse BRDF evaluator.
// Depends on nothing; every module of the block imports it.
package dbe_pkg;

  localparam int ANGLE_BITS_DEF   = 16;
  localparam int CHANNEL_BITS_DEF = 16;

  // Material selector codes
  typedef enum logic [1:0] {
    MAT_LAMBERT    = 2'd0,
    MAT_OREN_NAYAR = 2'd1,
    MAT_MIRROR     = 2'd2,
    MAT_EMISSIVE   = 2'd3
  } material_e;

  // Register indexes on the configuration port
  localparam logic [7:0] CFG_MATERIAL_KIND = 8'd0;
  localparam logic [7:0] CFG_RHO_RED       = 8'd1;
  localparam logic [7:0] CFG_RHO_GREEN     = 8'd2;
  localparam logic [7:0] CFG_RHO_BLUE      = 8'd3;
  localparam logic [7:0] CFG_ROUGHNESS     = 8'd4;

  // Roughness term divider sequencer
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_DIV_A = 2'd1,
    ST_DIV_B = 2'd2
  } div_state_e;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic step;
    logic done_a;
    logic done_b;
  } div_ctrl_t;

  // Sine polynomial, quarter-turn argument, Q1.30; index 0 is the degree-9 term
  localparam logic [4:0][31:0] SIN_COEF = {
    32'd1686629713, 32'd693598670, 32'd85569306, 32'd5026991, 32'd172272
  };
  localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
  localparam logic [31:0] QUARTER    = 32'h4000_0000;

  localparam logic [31:0] C033_Q28   = 32'd88583700;
  localparam logic [31:0] C009_Q28   = 32'd24159191;
  localparam logic [14:0] C045_Q16   = 15'd29491;
  localparam logic [30:0] INV_PI_Q32 = 31'd1367130551;
  localparam logic [23:0] TAN_MAX    = 24'hFF_FFFF;
  localparam logic [16:0] GAIN_ONE   = 17'h1_0000;

endpackage

[hw/rtl/dbe_sine_pipe.sv]
// Seven-stage pipelined sine magnitude and sign for a Q0.32 turn.
// Depends on dbe_pkg for the polynomial coefficients.
module dbe_sine_pipe import dbe_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] turn_i,
  output logic [30:0] mag_o,
  output logic        neg_o
);

  logic [30:0] x, u_d;
  logic [5:0][30:0] u_q;
  logic [5:0]       neg_q;
  logic [3:0][30:0] u2_q;
  logic [3:0][31:0] acc_q;
  logic [61:0] sq;
  logic [3:0][62:0] hprod;
  logic [62:0] fprod;
  logic [32:0] fm;

  assign x     = {1'b0, turn_i[29:0]};
  assign u_d   = turn_i[30] ? (ONE_Q30 - x) : x;
  assign sq    = u_q[0] * u_q[0];
  assign fprod = u_q[5] * acc_q[3];
  assign fm    = fprod[62:30];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      hprod[j] = u2_q[j] * ((j == 0) ? SIN_COEF[0] : acc_q[(j == 0) ? 0 : j - 1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q[0]   <= u_d;
      neg_q[0] <= turn_i[31];
      for (int k = 1; k < 6; k++) begin
        u_q[k]   <= u_q[k-1];
        neg_q[k] <= neg_q[k-1];
      end
      u2_q[0] <= sq[60:30];
      for (int k = 1; k < 4; k++) begin
        u2_q[k] <= u2_q[k-1];
      end
      for (int j = 0; j < 4; j++) begin
        acc_q[j] <= SIN_COEF[j+1] - hprod[j][61:30];
      end
      mag_o <= (fm > 33'(ONE_Q30)) ? ONE_Q30 : fm[30:0];
      neg_o <= neg_q[5];
    end
  end

endmodule

[hw/rtl/diffuse_brdf_evaluator_core.sv]
// Throughput: one word per cycle unless a result waits at the output or the A/B divide
//   runs; sine, divide and multiply stages are all pipelined.
// A roughness write sets a start flag that launches a serial divide for the A and B terms;
//   input tready and cfg_ready_o stay low while that flag is set and the divide runs.
// Reset: asynchronous, active low; config registers clear to zero, A to 1.0 and B to 0, pipeline empties.
// Depends on dbe_pkg and dbe_sine_pipe.
module diffuse_brdf_evaluator_core import dbe_pkg::*; #(
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // in_polar, in_azimuth, out_polar, out_azimuth (16 bits each, from bit 0 up)
  input  logic [63:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // red, green, blue (18 bits each, from bit 0 up), two zero pad bits on top
  output logic [55:0] m_axis_tdata,
  // saturated
  output logic        m_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int LAT = 37;
  localparam int SHR = 48 - CHANNEL_BITS;
  localparam logic [56:0] OUT_MAX = 57'((64'd4 << CHANNEL_BITS) - 64'd1);
  localparam logic [15:0] CHAN_MASK =
    (CHANNEL_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << CHANNEL_BITS) - 32'd1);
  localparam logic [31:0] ANGLE_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);

  function automatic logic [31:0] to_turns(input logic [15:0] a);
    logic [31:0] t;
    t = {16'b0, a} & ANGLE_MASK;
    return t << (32 - ANGLE_BITS);
  endfunction

  // ---------------------------------------------------------------- config
  material_e   mode_q;
  logic [15:0] rho_q [3];
  logic [15:0] rough_q;
  logic        start_q;
  logic        cfg_we;
  div_state_e  state_q, state_d;

  // Hold further writes while the A and B terms are being recomputed.
  assign cfg_ready_o = (state_q == ST_IDLE) && !start_q;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MAT_LAMBERT;
      rho_q[0] <= '0;
      rho_q[1] <= '0;
      rho_q[2] <= '0;
      rough_q  <= '0;
      start_q  <= 1'b0;
    end else begin
      start_q <= 1'b0;
      if (cfg_we) begin
        case (cfg_index_i)
          CFG_MATERIAL_KIND: mode_q   <= material_e'(cfg_data_i[1:0]);
          CFG_RHO_RED:       rho_q[0] <= cfg_data_i;
          CFG_RHO_GREEN:     rho_q[1] <= cfg_data_i;
          CFG_RHO_BLUE:      rho_q[2] <= cfg_data_i;
          CFG_ROUGHNESS: begin
            rough_q <= cfg_data_i;
            start_q <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // ------------------------------------------- A and B by a serial divider
  // A = 1 - s2/(2(s2+0.33)), B = 0.45 s2/(s2+0.09); both quotients fit 15 bits.
  div_ctrl_t   dctl;
  logic [3:0]  cnt_q;
  logic [33:0] rem_q, den_q;
  logic [15:0] nlo_q, quo_q;
  logic [31:0] s2_q, s2_now;
  logic [47:0] num_a, num_b;
  logic [34:0] rem_sh;
  logic        rge;
  logic [15:0] quo_d;
  logic [16:0] a_q;
  logic [15:0] b_q;

  assign s2_now = rough_q * rough_q;
  assign num_a  = {s2_now, 16'b0};
  assign num_b  = s2_q * C045_Q16;
  assign rem_sh = {rem_q, nlo_q[15]};
  assign rge    = rem_sh >= {1'b0, den_q};
  assign quo_d  = {quo_q[14:0], rge};

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (start_q) state_d = ST_DIV_A;
      ST_DIV_A: if (cnt_q == 4'hF) state_d = ST_DIV_B;
      ST_DIV_B: if (cnt_q == 4'hF) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    dctl = '0;
    case (state_q)
      ST_IDLE:  dctl.load_a = start_q;
      ST_DIV_A: begin
        dctl.step   = 1'b1;
        dctl.done_a = (cnt_q == 4'hF);
        dctl.load_b = (cnt_q == 4'hF);
      end
      ST_DIV_B: begin
        dctl.step   = 1'b1;
        dctl.done_b = (cnt_q == 4'hF);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      a_q     <= GAIN_ONE;
      b_q     <= '0;
    end else begin
      state_q <= state_d;
      if (dctl.step) cnt_q <= cnt_q + 4'd1;
      if (dctl.load_a) cnt_q <= '0;
      if (dctl.done_a) a_q <= GAIN_ONE - {1'b0, quo_d};
      if (dctl.done_b) b_q <= quo_d;
    end
  end

  // Divider datapath: the starting remainder is below the divisor by construction.
  always_ff @(posedge clk_i) begin
    if (dctl.load_a) begin
      s2_q  <= s2_now;
      rem_q <= {2'b0, num_a[47:16]};
      nlo_q <= num_a[15:0];
      den_q <= {33'(s2_now) + 33'(C033_Q28), 1'b0};
      quo_q <= '0;
    end else if (dctl.load_b) begin
      rem_q <= {2'b0, num_b[47:16]};
      nlo_q <= num_b[15:0];
      den_q <= {1'b0, 33'(s2_q) + 33'(C009_Q28)};
      quo_q <= '0;
    end else if (dctl.step) begin
      rem_q <= rge ? 34'(rem_sh - {1'b0, den_q}) : rem_sh[33:0];
      nlo_q <= {nlo_q[14:0], 1'b0};
      quo_q <= quo_d;
    end
  end

  // --------------------------------------------------------- stream control
  // The whole pipeline advances unless a finished word waits at the output.
  logic           en;
  logic [LAT-1:0] vld_q;

  assign en            = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = en && (state_q == ST_IDLE) && !start_q;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid && s_axis_tready};
    end
  end

  // ------------------------------------------- stage 0: angles in Q0.32 turns
  logic [31:0] pi_q, po_q, dphi_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pi_q   <= to_turns(s_axis_tdata[15:0]);
      po_q   <= to_turns(s_axis_tdata[47:32]);
      dphi_q <= to_turns(s_axis_tdata[31:16]) - to_turns(s_axis_tdata[63:48]);
    end
  end

  // --------------------------------------- stages 1-7: four sine pipelines
  logic [31:0] alpha, beta;
  logic [30:0] cosd_m, sina_m, sb_m, cb_m;
  logic        cosd_n, sina_n, sb_n, cb_n;
  logic [6:0]  bge_q;

  assign alpha = (pi_q > po_q) ? pi_q : po_q;
  assign beta  = (pi_q > po_q) ? po_q : pi_q;

  dbe_sine_pipe u_sin_cosd (
    .clk_i(clk_i), .en_i(en), .turn_i(dphi_q + QUARTER), .mag_o(cosd_m), .neg_o(cosd_n));
  dbe_sine_pipe u_sin_alpha (
    .clk_i(clk_i), .en_i(en), .turn_i(alpha), .mag_o(sina_m), .neg_o(sina_n));
  dbe_sine_pipe u_sin_beta (
    .clk_i(clk_i), .en_i(en), .turn_i(beta), .mag_o(sb_m), .neg_o(sb_n));
  dbe_sine_pipe u_cos_beta (
    .clk_i(clk_i), .en_i(en), .turn_i(beta + QUARTER), .mag_o(cb_m), .neg_o(cb_n));

  // The signs of sin(beta) and cos(beta) play no part in the tangent.
  logic sign_unused;
  assign sign_unused = sb_n ^ cb_n;

  always_ff @(posedge clk_i) begin
    if (en) bge_q <= {bge_q[5:0], beta >= QUARTER};
  end

  // --------------------- stage 8 and 24 divide stages: tan(beta) in Q8.16
  // Overflow (quotient at or above 2^24, or a zero cosine, or beta at or past a
  // quarter turn) forces the tangent to its maximum and, in Oren-Nayar mode, raises saturated.
  logic [24:0][30:0] r_q, cb_q;
  logic [24:0][23:0] q_q;
  logic [24:0][7:0]  lo_q;
  logic [24:0]       ov_q;
  logic [24:0][15:0] t_q;
  logic [30:0]       sina0_q;
  logic [46:0]       t1_prod;
  logic [46:0]       t2_prod;

  assign t1_prod = b_q * (cosd_n ? 31'd0 : cosd_m);
  assign t2_prod = t_q[0] * sina0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q[0]  <= {8'b0, sb_m[30:8]};
      lo_q[0] <= sb_m[7:0];
      cb_q[0] <= cb_m;
      q_q[0]  <= '0;
      ov_q[0] <= bge_q[6] || ({8'b0, sb_m} >= {cb_m, 8'b0});
      t_q[0]  <= t1_prod[45:30];
      sina0_q <= sina_n ? 31'd0 : sina_m;
    end
  end

  for (genvar k = 0; k < 24; k++) begin : g_div
    localparam int IB = 23 - k;
    logic        nb;
    logic [31:0] rsh;
    logic        ge;

    if (IB >= 16) begin : g_lo
      assign nb = lo_q[k][IB-16];
    end else begin : g_zero
      assign nb = 1'b0;
    end

    assign rsh = {r_q[k], nb};
    assign ge  = rsh >= {1'b0, cb_q[k]};

    always_ff @(posedge clk_i) begin
      if (en) begin
        r_q[k+1]  <= ge ? 31'(rsh - {1'b0, cb_q[k]}) : rsh[30:0];
        q_q[k+1]  <= {q_q[k][22:0], ge};
        cb_q[k+1] <= cb_q[k];
        lo_q[k+1] <= lo_q[k];
        ov_q[k+1] <= ov_q[k];
        t_q[k+1]  <= (k == 0) ? t2_prod[45:30] : t_q[k];
      end
    end
  end

  // Final remainder, cosine and low byte leave the divider unread.
  logic div_unused;
  assign div_unused = ^{r_q[24], cb_q[24], lo_q[24]};

  // ---------------------------------------- stages 33-35: gain and products
  logic [23:0] tanb;
  logic [39:0] t3_prod;
  logic [22:0] t3_q;
  logic        ts_q [3];
  logic [24:0] gain_q;
  logic [31:0] rop_q [3];
  logic [56:0] vsh_q [3];
  logic [56:0] prod [3];

  assign tanb    = ov_q[24] ? TAN_MAX : q_q[24];
  assign t3_prod = t_q[24] * tanb;

  // rho/pi only follows configuration; hold it registered beside the pipe.
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      rop_q[c] <= 32'((48'(rho_q[c] & CHAN_MASK) * 48'(INV_PI_Q32)) >> CHANNEL_BITS);
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = 57'(rop_q[c] * gain_q) >> SHR;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t3_q   <= t3_prod[38:16];
      ts_q[0] <= ov_q[24];
      gain_q <= (mode_q == MAT_OREN_NAYAR) ? (25'(a_q) + 25'(t3_q)) : 25'(GAIN_ONE);
      ts_q[1] <= ts_q[0];
      for (int c = 0; c < 3; c++) vsh_q[c] <= prod[c];
      ts_q[2] <= ts_q[1];
    end
  end

  // ------------------------------------------------ stage 36: output word
  logic [17:0] chan_q [3];
  logic        sat_q;
  logic [17:0] chan_d [3];
  logic        sat_d;

  always_comb begin
    sat_d = 1'b0;
    for (int c = 0; c < 3; c++) begin
      chan_d[c] = 18'(vsh_q[c]);
    end
    case (mode_q)
      MAT_LAMBERT, MAT_OREN_NAYAR: begin
        sat_d = (mode_q == MAT_OREN_NAYAR) && ts_q[2];
        for (int c = 0; c < 3; c++) begin
          if (vsh_q[c] > OUT_MAX) begin
            chan_d[c] = 18'(OUT_MAX);
            sat_d     = 1'b1;
          end
        end
      end
      MAT_MIRROR: begin
        for (int c = 0; c < 3; c++) chan_d[c] = 18'(64'd1 << CHANNEL_BITS);
      end
      default: begin
        for (int c = 0; c < 3; c++) chan_d[c] = 18'(rho_q[c] & CHAN_MASK);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) chan_q[c] <= chan_d[c];
      sat_q <= sat_d;
    end
  end

  assign m_axis_tdata = {2'b0, chan_q[2], chan_q[1], chan_q[0]};
  assign m_axis_tuser = sat_q;

  // ------------------------------------------------------------ assertions
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_axis_tready)
    else $error("input taken while A/B divide runs");

  a_flat_no_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (mode_q == MAT_MIRROR || mode_q == MAT_EMISSIVE)) |-> !m_axis_tuser)
    else $error("saturated set in mirror or emissive mode");

  a_a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_q > 17'h0_8000)
    else $error("A term out of range");

  a_start_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_q && state_q == ST_IDLE) |=> (state_q == ST_DIV_A))
    else $error("roughness write did not start the divider");

endmodule

[bench/diffuse_brdf_evaluator_core_test.sv]
// Self-checking bench for diffuse_brdf_evaluator_core: drives angle words, predicts
// the RGB reflectance in fixed point and compares every result word in order.
// Depends on dbe_pkg and the RTL of the block.
`timescale 1ns / 100ps

module diffuse_brdf_evaluator_core_test;
  import dbe_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int RANDOM_ITEMS   = 1800;

  typedef struct packed {
    logic [17:0] red;
    logic [17:0] green;
    logic [17:0] blue;
    logic        saturated;
  } shade_word_t;

  typedef struct {
    logic [15:0] in_polar;
    logic [15:0] in_azimuth;
    logic [15:0] out_polar;
    logic [15:0] out_azimuth;
    logic        typed;
    shade_word_t want;
  } angle_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic [63:0] s_axis_tdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  diffuse_brdf_evaluator_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Bench copy of the configuration registers
  material_e   mat_q;
  logic [15:0] rho_r_q, rho_g_q, rho_b_q, rough_q;

  shade_word_t pending_shades[$];
  int          mismatches;
  int          idle_pct;
  int          stall_pct;
  int          quiet_cycles;
  bit          timed_out;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Sine magnitude in Q1.30 of a Q0.32 turn; sign returned separately
  function automatic logic [63:0] sine_q30(input logic [31:0] t, output bit neg);
    logic [63:0] x, u, u2, acc;
    x   = {34'd0, t[29:0]};
    u   = t[30] ? ({33'd0, ONE_Q30} - x) : x;
    u2  = (u * u) >> 30;
    acc = SIN_COEF[0];
    acc = SIN_COEF[1] - ((u2 * acc) >> 30);
    acc = SIN_COEF[2] - ((u2 * acc) >> 30);
    acc = SIN_COEF[3] - ((u2 * acc) >> 30);
    acc = SIN_COEF[4] - ((u2 * acc) >> 30);
    acc = (u * acc) >> 30;
    if (acc > ONE_Q30) acc = ONE_Q30;
    neg = t[31];
    return acc;
  endfunction

  function automatic logic [63:0] channel_level(input logic [15:0] rho,
                                                input logic [63:0] gain, inout bit sat);
    logic [63:0] rop, v;
    rop = ({48'd0, rho} * INV_PI_Q32) >> 16;
    v   = (rop * gain) >> 32;
    if (v > 64'h3FFFF) begin
      sat = 1'b1;
      v   = 64'h3FFFF;
    end
    return v;
  endfunction

  function automatic shade_word_t predict_shade(input logic [15:0] ip, input logic [15:0] ia,
                                                input logic [15:0] op, input logic [15:0] oa);
    shade_word_t w;
    bit          sat, neg;
    logic [63:0] s2, a_term, b_term, cosd, sina, sb, cb, tanb, t, gain;
    logic [31:0] pin, pout, alpha, beta, dphi;
    sat = 1'b0;
    w   = '0;
    case (mat_q)
      MAT_LAMBERT: gain = 64'h1_0000;
      MAT_OREN_NAYAR: begin
        s2     = {48'd0, rough_q} * {48'd0, rough_q};
        a_term = 64'd65536 - ((s2 << 16) / (2 * (s2 + C033_Q28)));
        b_term = (C045_Q16 * s2) / (s2 + C009_Q28);
        pin    = {ip, 16'd0};
        pout   = {op, 16'd0};
        alpha  = (pin > pout) ? pin : pout;
        beta   = (pin > pout) ? pout : pin;
        dphi   = {ia, 16'd0} - {oa, 16'd0};
        cosd   = sine_q30(dphi + QUARTER, neg);
        if (neg) cosd = 0;
        sina = sine_q30(alpha, neg);
        if (neg) sina = 0;
        if (beta >= QUARTER) begin
          tanb = TAN_MAX;
          sat  = 1'b1;
        end else begin
          sb = sine_q30(beta, neg);
          cb = sine_q30(beta + QUARTER, neg);
          if (cb == 0) begin
            tanb = TAN_MAX;
            sat  = 1'b1;
          end else begin
            tanb = (sb << 16) / cb;
            if (tanb > TAN_MAX) begin
              tanb = TAN_MAX;
              sat  = 1'b1;
            end
          end
        end
        t    = (b_term * cosd) >> 30;
        t    = (t * sina) >> 30;
        t    = (t * tanb) >> 16;
        gain = a_term + t;
      end
      default: gain = 0;
    endcase
    case (mat_q)
      MAT_MIRROR: begin
        w.red   = 18'h1_0000;
        w.green = 18'h1_0000;
        w.blue  = 18'h1_0000;
      end
      MAT_EMISSIVE: begin
        w.red   = {2'b0, rho_r_q};
        w.green = {2'b0, rho_g_q};
        w.blue  = {2'b0, rho_b_q};
      end
      default: begin
        w.red   = 18'(channel_level(rho_r_q, gain, sat));
        w.green = 18'(channel_level(rho_g_q, gain, sat));
        w.blue  = 18'(channel_level(rho_b_q, gain, sat));
      end
    endcase
    w.saturated = sat;
    return w;
  endfunction

  // Register write over the config channel; mirror it in the bench copy.
  // Valid stays up after the write; load_material drops it.
  task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    case (idx)
      CFG_MATERIAL_KIND: mat_q   = material_e'(val[1:0]);
      CFG_RHO_RED:       rho_r_q = val;
      CFG_RHO_GREEN:     rho_g_q = val;
      CFG_RHO_BLUE:      rho_b_q = val;
      CFG_ROUGHNESS:     rough_q = val;
      default: ;
    endcase
  endtask

  // Let the pipeline drain before touching the registers
  task automatic settle_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_shades.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_material(input material_e m, input logic [15:0] r, input logic [15:0] g,
                               input logic [15:0] b, input logic [15:0] sigma);
    settle_idle();
    write_reg(CFG_MATERIAL_KIND, {14'd0, m});
    write_reg(CFG_RHO_RED, r);
    write_reg(CFG_RHO_GREEN, g);
    write_reg(CFG_RHO_BLUE, b);
    write_reg(CFG_ROUGHNESS, sigma);
    write_reg(8'd7, 16'hFFFF);  // unmapped index, must be dropped
    cfg_valid_i <= 1'b0;
  endtask

  // Send one angle word; the expectation is queued on acceptance.
  // Valid stays up after the word; the next idle cycle or the caller drops it.
  task automatic send_angles(input logic [15:0] ip, input logic [15:0] ia,
                             input logic [15:0] op, input logic [15:0] oa,
                             input bit typed, input shade_word_t want);
    shade_word_t model;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    model = predict_shade(ip, ia, op, oa);
    if (typed && model != want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("typed row disagrees with predictor: typed %h predicted %h", want, model);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {oa, op, ia, ip};
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    pending_shades.push_back(model);
  endtask

  // Receiver: stall at random, compare each accepted result word
  always @(posedge clk_i) begin
    shade_word_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[17:0], m_axis_tdata[35:18], m_axis_tdata[53:36], m_axis_tuser};
        if (pending_shades.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %h", got);
        end else begin
          want = pending_shades.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected r %h g %h b %h sat %b, got r %h g %h b %h sat %b",
                       want.red, want.green, want.blue, want.saturated,
                       got.red, got.green, got.blue, got.saturated);
          end
        end
      end
      m_axis_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog on cycles with no handshake anywhere
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out) begin
        timed_out = 1'b1;
        $display("diffuse_brdf_evaluator_core verification failed");
        $finish;
      end
    end
  end

  angle_row_t  steps[$];
  shade_word_t zero_word, mirror_word;
  material_e   mat_pick;

  initial begin
    angle_row_t row;
    int         k;
    mismatches    = 0;
    idle_pct      = 36;
    stall_pct     = 36;
    quiet_cycles  = 0;
    timed_out     = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    mat_q = MAT_LAMBERT;
    {rho_r_q, rho_g_q, rho_b_q, rough_q} = '0;
    zero_word   = '0;
    mirror_word = '{red: 18'h1_0000, green: 18'h1_0000, blue: 18'h1_0000, saturated: 1'b0};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: after reset rho is zero so lambertian gives zero
    steps.push_back('{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, zero_word});
    steps.push_back('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, zero_word});
    foreach (steps[i])
      send_angles(steps[i].in_polar, steps[i].in_azimuth, steps[i].out_polar,
                  steps[i].out_azimuth, steps[i].typed, steps[i].want);

    load_material(MAT_MIRROR, 16'hFFFF, 16'h0000, 16'h1234, 16'hFFFF);
    send_angles(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 1'b1, mirror_word);
    load_material(MAT_EMISSIVE, 16'hFFFF, 16'h0000, 16'hA5A5, 16'h0000);
    send_angles(16'h1111, 16'h2222, 16'h3333, 16'h4444, 1'b1,
                '{red: 18'hFFFF, green: 18'h0, blue: 18'hA5A5, saturated: 1'b0});
    load_material(MAT_LAMBERT, 16'hFFFF, 16'h8000, 16'h0001, 16'h0000);
    send_angles(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, zero_word);

    // Oren-Nayar corners: smooth and max roughness, tangent clip, negative cosines
    steps.delete();
    steps.push_back('{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, zero_word});
    steps.push_back('{16'h2000, 16'h0000, 16'h1000, 16'h0000, 1'b0, zero_word});
    steps.push_back('{16'h3FFF, 16'h0000, 16'h3FFF, 16'h0000, 1'b0, zero_word}); // huge tan
    steps.push_back('{16'h4000, 16'h0000, 16'h4000, 16'h0000, 1'b0, zero_word}); // beta quarter
    steps.push_back('{16'h2000, 16'h8000, 16'h1000, 16'h0000, 1'b0, zero_word}); // cos < 0
    steps.push_back('{16'hC000, 16'h1000, 16'h1000, 16'h0000, 1'b0, zero_word}); // sin(a) < 0
    steps.push_back('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, zero_word});
    steps.push_back('{16'h0800, 16'h4000, 16'h3800, 16'hC000, 1'b0, zero_word});
    foreach (steps[i]) begin
      if (i == 0) load_material(MAT_OREN_NAYAR, 16'hFFFF, 16'h8000, 16'h0001, 16'hFFFF);
      send_angles(steps[i].in_polar, steps[i].in_azimuth, steps[i].out_polar,
                  steps[i].out_azimuth, 1'b0, zero_word);
    end
    load_material(MAT_OREN_NAYAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    foreach (steps[i])
      send_angles(steps[i].in_polar, steps[i].in_azimuth, steps[i].out_polar,
                  steps[i].out_azimuth, 1'b0, zero_word);

    // Random phases; one phase runs with no idling on either side
    for (int ph = 0; ph < 12; ph++) begin
      mat_pick = (ph % 3 == 0) ? MAT_OREN_NAYAR : material_e'($urandom_range(3));
      load_material(mat_pick, 16'($urandom), 16'($urandom), 16'($urandom),
                    (ph == 4) ? 16'hFFFF : ((ph == 5) ? 16'h0000 : 16'($urandom)));
      idle_pct  = (ph == 2) ? 0 : 36;
      stall_pct = (ph == 2) ? 0 : 36;
      for (k = 0; k < RANDOM_ITEMS / 12; k++) begin
        // Bias half the polar angles into the quarter turn where tangent is defined
        row.in_polar    = $urandom_range(1) ? 16'($urandom_range(16'h3FFF)) : 16'($urandom);
        row.out_polar   = $urandom_range(1) ? 16'($urandom_range(16'h3FFF)) : 16'($urandom);
        row.in_azimuth  = 16'($urandom);
        row.out_azimuth = 16'($urandom);
        send_angles(row.in_polar, row.in_azimuth, row.out_polar, row.out_azimuth,
                    1'b0, zero_word);
        // Hold the sender until everything is back, once per phase
        if (k == 40) begin
          s_axis_tvalid <= 1'b0;
          while (pending_shades.size() != 0) @(posedge clk_i);
        end
      end
    end

    idle_pct = 0;
    s_axis_tvalid <= 1'b0;
    while (pending_shades.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_shades.size() == 0) begin
      $display("diffuse_brdf_evaluator_core verification clean");
    end else begin
      $display("diffuse_brdf_evaluator_core verification failed");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/dbe_pkg.sv
hw/rtl/dbe_sine_pipe.sv
hw/rtl/diffuse_brdf_evaluator_core.sv
bench/diffuse_brdf_evaluator_core_test.sv
